### sv/paced_announcement_queue_defines.svh
// Assertion macros for the paced announcement queue RTL.
// Included by paced_announcement_queue, which carries concurrent assertions; no other dependencies.
`ifndef PACED_ANNOUNCEMENT_QUEUE_DEFINES_SVH
`define PACED_ANNOUNCEMENT_QUEUE_DEFINES_SVH

`ifndef ASSERT_OFF
// Checked on every clock edge outside reset.
`define PAQ_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every clock edge, including during reset.
`define PAQ_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PAQ_ASSERT(label, clk, rst_n, prop, msg)
`define PAQ_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

### sv/paq_pkg.sv
// Types and constants of the paced announcement queue.
// No dependencies; used by the interfaces, the paced_announcement_queue module and the testbench.
`default_nettype none

package paq_pkg;

    localparam int KIND_W   = 2;
    localparam int CALL_IN_W = 16;
    localparam int CALL_W   = 15;
    localparam int GAP_W    = 16;
    localparam int STATUS_W = 2;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [CALL_W-1:0] VOICE_THRESHOLD_RESET = CALL_W'(224);

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK          = 2'd0,
        KIND_ADD           = 2'd1,
        KIND_ADD_IF_SILENT = 2'd2
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_DONE       = 2'd0,
        STATUS_IDLE_TICK  = 2'd1,
        STATUS_RANGE      = 2'd2,
        STATUS_NOT_SILENT = 2'd3
    } status_t;

    // Register index, taken from the word address bit of the APB port.
    typedef enum logic {
        REG_GAP_TICKS       = 1'b0,
        REG_VOICE_THRESHOLD = 1'b1
    } reg_index_t;

endpackage

`default_nettype wire

### sv/paq_if.sv
// Valid/ready channel interfaces for queue commands and results.
// Depends on paq_pkg for the field widths.
`default_nettype none

interface paq_cmd_if
    import paq_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [KIND_W-1:0]    kind;
    logic [CALL_IN_W-1:0] call_number;

    modport source (output valid, output kind, output call_number, input ready);
    modport sink (input valid, input kind, input call_number, output ready);
endinterface

interface paq_rsp_if
    import paq_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [CALL_W-1:0]   played_call;
    logic                played_is_voice;
    logic                now_silent;

    modport source (output valid, output status, output played_call,
                    output played_is_voice, output now_silent, input ready);
    modport sink (input valid, input status, input played_call,
                  input played_is_voice, input now_silent, output ready);
endinterface

`default_nettype wire

### sv/paced_announcement_queue.sv
// A command's result is loaded into the output register when the command is accepted.
// Throughput: one command per cycle while results are taken, set by the
// single result register and the call store's one write and one registered read port.
// Reset clears the pointers, the hold-off timer and the output valid, sets gap_ticks to 0
// and voice_threshold to 224. The call store is not cleared; it needs no clearing pass.
// Depends on paq_pkg, paq_if, paq_ram and paced_announcement_queue_defines.svh.
`default_nettype none
`include "paced_announcement_queue_defines.svh"

module paced_announcement_queue
    import paq_pkg::*;
#(
    parameter int QUEUE_SLOTS = 8
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    paq_cmd_if.sink                    cmd,
    paq_rsp_if.source                  rsp,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output      logic [APB_DATA_W-1:0] prdata,
    output      logic                  pready
);

    localparam int PTR_W = $clog2(QUEUE_SLOTS);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_SLOTS - 1);

    function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
        advance = (p == LAST_SLOT) ? '0 : p + PTR_W'(1);
    endfunction

    // Configuration registers.
    logic [GAP_W-1:0]  gap_ticks_reg;
    logic [CALL_W-1:0] voice_threshold_reg;
    logic              cfg_write;
    reg_index_t        cfg_index;

    // Queue state.
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [GAP_W-1:0]  hold_reg, hold_next;

    // Store read path with bypass for an entry written while it was being read.
    logic              store_we;
    logic [CALL_W-1:0] ram_q;
    logic              byp_valid_reg, byp_valid_next;
    logic [CALL_W-1:0] byp_data_reg;
    logic [CALL_W-1:0] head_call;

    // Result register.
    logic              out_valid_reg, out_valid_next;
    status_t           rsp_status_reg, status_next;
    logic [CALL_W-1:0] rsp_played_reg, played_next;
    logic              rsp_voice_reg, voice_next;
    logic              rsp_silent_reg, silent_next;

    logic              cmd_fire;
    logic              silent_now;
    logic              add_req;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = reg_index_t'(paddr[2]);

    always_comb
    begin
        case (cfg_index)
            REG_GAP_TICKS:       prdata = APB_DATA_W'(gap_ticks_reg);
            REG_VOICE_THRESHOLD: prdata = APB_DATA_W'(voice_threshold_reg);
            default:             prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_ticks_reg       <= '0;
            voice_threshold_reg <= VOICE_THRESHOLD_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_GAP_TICKS:       gap_ticks_reg       <= pwdata[GAP_W-1:0];
                REG_VOICE_THRESHOLD: voice_threshold_reg <= pwdata[CALL_W-1:0];
                default:             gap_ticks_reg       <= gap_ticks_reg;
            endcase
        end
    end

    assign cmd.ready  = !out_valid_reg || rsp.ready;
    assign cmd_fire   = cmd.valid && cmd.ready;
    assign silent_now = (wr_ptr_reg == rd_ptr_reg) && (hold_reg == '0);
    assign head_call  = byp_valid_reg ? byp_data_reg : ram_q;

    // Add-if-silent turns into a plain add when the queue is silent before the step.
    assign add_req = (kind_t'(cmd.kind) == KIND_ADD)
                  || ((kind_t'(cmd.kind) == KIND_ADD_IF_SILENT) && silent_now);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        hold_next   = hold_reg;
        store_we    = 1'b0;
        status_next = STATUS_IDLE_TICK;
        played_next = '0;
        voice_next  = 1'b0;
        if (cmd_fire)
        begin
            if (add_req)
            begin
                if (cmd.call_number[CALL_IN_W-1])
                begin
                    status_next = STATUS_RANGE;
                end
                else
                begin
                    store_we    = 1'b1;
                    wr_ptr_next = advance(wr_ptr_reg);
                    status_next = STATUS_DONE;
                end
            end
            else
            begin
                case (kind_t'(cmd.kind))
                    KIND_TICK:
                    begin
                        if (hold_reg != '0)
                        begin
                            hold_next = hold_reg - GAP_W'(1);
                        end
                        else if (wr_ptr_reg != rd_ptr_reg)
                        begin
                            rd_ptr_next = advance(rd_ptr_reg);
                            played_next = head_call;
                            voice_next  = (head_call >= voice_threshold_reg);
                            hold_next   = gap_ticks_reg;
                            status_next = STATUS_DONE;
                        end
                    end
                    KIND_ADD_IF_SILENT: status_next = STATUS_NOT_SILENT;
                    default:            status_next = STATUS_IDLE_TICK;
                endcase
            end
        end
        silent_next    = (wr_ptr_next == rd_ptr_next) && (hold_next == '0);
        byp_valid_next = store_we && (wr_ptr_reg == rd_ptr_next);
        if (cmd_fire)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && !rsp.ready;
        end
    end

    paq_ram #(
        .WIDTH (CALL_W),
        .DEPTH (QUEUE_SLOTS)
    ) u_call_store (
        .clk     (clk),
        .we      (store_we),
        .wr_addr (wr_ptr_reg),
        .wr_data (cmd.call_number[CALL_W-1:0]),
        .rd_addr (rd_ptr_next),
        .rd_data (ram_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            hold_reg      <= '0;
            byp_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            hold_reg      <= hold_next;
            byp_valid_reg <= byp_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byp_data_reg <= cmd.call_number[CALL_W-1:0];
        if (cmd_fire)
        begin
            rsp_status_reg <= status_next;
            rsp_played_reg <= played_next;
            rsp_voice_reg  <= voice_next;
            rsp_silent_reg <= silent_next;
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.status          = rsp_status_reg;
    assign rsp.played_call     = rsp_played_reg;
    assign rsp.played_is_voice = rsp_voice_reg;
    assign rsp.now_silent      = rsp_silent_reg;

    `PAQ_ASSERT(a_play_reloads_timer, clk, rst_n,
        cmd_fire && (kind_t'(cmd.kind) == KIND_TICK) && (hold_reg == '0)
        && (wr_ptr_reg != rd_ptr_reg) |=> (hold_reg == $past(gap_ticks_reg)),
        "hold-off timer not reloaded after a play")
    `PAQ_ASSERT(a_silent_matches_state, clk, rst_n,
        cmd_fire |=> (rsp_silent_reg == ((wr_ptr_reg == rd_ptr_reg) && (hold_reg == '0))),
        "reported silence differs from queue state")
    `PAQ_ASSERT(a_refused_keeps_pointers, clk, rst_n,
        cmd_fire && (status_next != STATUS_DONE) |=> $stable(wr_ptr_reg) && $stable(rd_ptr_reg),
        "pointer moved on a refused or idle command")
    `PAQ_ASSERT(a_played_only_when_done, clk, rst_n,
        out_valid_reg && (rsp_status_reg != STATUS_DONE) |-> (rsp_played_reg == '0) && !rsp_voice_reg,
        "played fields set without a play")
    // A clock edge seen in reset leaves the control state cleared after it.
    `PAQ_ASSERT_ALWAYS(a_no_bypass_in_reset, clk,
        !rst_n |=> !byp_valid_reg && !out_valid_reg,
        "control state not cleared in reset")

endmodule

`default_nettype wire

### sv/paq_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies. A read of the address being written returns the old data.
`default_nettype none

module paq_ram #(
    parameter int WIDTH = 15,
    parameter int DEPTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output      logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### tb/sv/paced_announcement_queue_tb.sv
// Self-checking testbench for the paced announcement queue: valid/ready command and result
// channels with random idling, APB register writes between phases, and a result predictor.
// Depends on paq_pkg, paq_if and the paced_announcement_queue RTL.
module paced_announcement_queue_tb;
    import paq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS = 8;
    localparam int LIMIT_CYCLES = 400000;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam logic [CALL_IN_W-1:0] MAX_CALL = 16'h7FFF;

    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [CALL_IN_W-1:0] call;
    } call_cmd_t;

    typedef struct packed {
        status_t           status;
        logic [CALL_W-1:0] played;
        logic              voice;
        logic              silent;
    } outcome_t;

    logic clk = 1'b0;
    logic rst_n;

    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    paq_cmd_if cmd_ch ();
    paq_rsp_if rsp_ch ();

    paced_announcement_queue #(
        .QUEUE_SLOTS(SLOTS)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd_ch),
        .rsp    (rsp_ch),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready)
    );

    always #1 clk = ~clk;

    // Predictor state and its copy of the registers.
    logic [CALL_W-1:0] slot_calls [SLOTS];
    int unsigned       wr_ptr;
    int unsigned       rd_ptr;
    logic [GAP_W-1:0]  holdoff;
    logic [GAP_W-1:0]  gap_cfg;
    logic [CALL_W-1:0] voice_cfg;

    call_cmd_t call_commands [$];
    outcome_t  announcer_outcomes [$];

    bit idling_on;
    int items_queued;
    int cmds_accepted;
    int mismatches;
    int calls_played;
    int voice_played;
    int range_refusals;
    int silent_refusals;
    int settings_count;
    int cycle_count;
    int send_gap;
    int recv_stall;

    function automatic int unsigned next_slot(input int unsigned p);
        return (p == SLOTS - 1) ? 0 : p + 1;
    endfunction

    function automatic bit queue_silent();
        return (wr_ptr == rd_ptr) && (holdoff == '0);
    endfunction

    function automatic status_t store_call(input logic [CALL_IN_W-1:0] call);
        if (call > MAX_CALL)
            return STATUS_RANGE;
        slot_calls[wr_ptr] = call[CALL_W-1:0];
        wr_ptr = next_slot(wr_ptr);
        return STATUS_DONE;
    endfunction

    function automatic outcome_t announcer_step(input logic [KIND_W-1:0] kind,
                                                input logic [CALL_IN_W-1:0] call);
        outcome_t res;
        res.status = STATUS_IDLE_TICK;
        res.played = '0;
        res.voice  = 1'b0;
        case (kind)
            KIND_TICK:
            begin
                if (holdoff != '0) begin
                    holdoff = holdoff - 1'b1;
                end
                else if (wr_ptr != rd_ptr) begin
                    res.played = slot_calls[rd_ptr];
                    res.voice  = (slot_calls[rd_ptr] >= voice_cfg);
                    rd_ptr     = next_slot(rd_ptr);
                    holdoff    = gap_cfg;
                    res.status = STATUS_DONE;
                end
            end
            KIND_ADD:
                res.status = store_call(call);
            KIND_ADD_IF_SILENT:
                res.status = queue_silent() ? store_call(call) : STATUS_NOT_SILENT;
            default:
                ;
        endcase
        res.silent = queue_silent();
        return res;
    endfunction

    function automatic logic [CALL_IN_W-1:0] pick_call();
        logic [CALL_IN_W-1:0] c;
        case ($urandom_range(0, 9))
            0: c = MAX_CALL;
            1: c = '0;
            2: c = CALL_IN_W'(voice_cfg);
            3: c = (voice_cfg == '0) ? '0 : CALL_IN_W'(voice_cfg - 1'b1);
            4: c = CALL_IN_W'($urandom_range(32'h8000, 32'hFFFF));
            default: c = CALL_IN_W'($urandom_range(0, 32'h7FFF));
        endcase
        return c;
    endfunction

    task automatic add_cmd(input logic [KIND_W-1:0] kind, input logic [CALL_IN_W-1:0] call);
        call_commands.push_back('{kind: kind, call: call});
        if (kind != KIND_UNUSED)
            items_queued++;
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [APB_DATA_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= APB_ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_GAP_TICKS)
            gap_cfg = value[GAP_W-1:0];
        else
            voice_cfg = value[CALL_W-1:0];
    endtask

    // Upper data bits are random; the registers keep only their own width.
    task automatic apply_setting(input int gap, input int threshold);
        write_reg(REG_GAP_TICKS, {16'($urandom), GAP_W'(gap)});
        write_reg(REG_VOICE_THRESHOLD, {17'($urandom), CALL_W'(threshold)});
        settings_count++;
    endtask

    // Returns once every command is accepted and every result has come back.
    task automatic wait_drained();
        @(negedge clk);
        while (call_commands.size() != 0 || cmd_ch.valid || announcer_outcomes.size() != 0)
            @(negedge clk);
        repeat (3) @(posedge clk);
    endtask

    // Mostly bursts of adds followed by ticks to play them out (at most 50 ticks), plus noise.
    task automatic fill_random(input int target);
        int stop_at;
        int roll;
        int burst;
        int drain;
        int k;
        stop_at = items_queued + target;
        @(negedge clk);
        while (items_queued < stop_at) begin
            roll = $urandom_range(0, 99);
            if (roll < 65) begin
                burst = (roll < 6) ? $urandom_range(8, 11) : $urandom_range(1, 6);
                drain = burst * (int'(gap_cfg) + 1);
                if (drain > 48)
                    drain = $urandom_range(1, 48);
                repeat (burst)
                    add_cmd(($urandom_range(0, 7) == 0) ? KIND_ADD_IF_SILENT : KIND_ADD,
                            pick_call());
                repeat (drain + $urandom_range(0, 2))
                    add_cmd(KIND_TICK, CALL_IN_W'($urandom));
            end
            else if (roll < 80) begin
                add_cmd(KIND_ADD_IF_SILENT, pick_call());
                add_cmd(KIND_TICK, CALL_IN_W'($urandom));
            end
            else begin
                k = $urandom_range(0, 3);
                add_cmd(KIND_W'(k), CALL_IN_W'($urandom));
            end
        end
    endtask

    always @(posedge clk) begin : drive_channels
        call_cmd_t nxt;
        if (!rst_n) begin
            cmd_ch.valid <= 1'b0;
            rsp_ch.ready <= 1'b0;
            send_gap     <= 0;
            recv_stall   <= 0;
        end
        else begin
            if (!cmd_ch.valid || cmd_ch.ready) begin
                if (send_gap > 0) begin
                    cmd_ch.valid <= 1'b0;
                    send_gap     <= send_gap - 1;
                end
                else if (call_commands.size() != 0) begin
                    nxt = call_commands.pop_front();
                    cmd_ch.valid       <= 1'b1;
                    cmd_ch.kind        <= nxt.kind;
                    cmd_ch.call_number <= nxt.call;
                    if (idling_on && $urandom_range(0, 15) == 0)
                        send_gap <= $urandom_range(1, 10);
                end
                else begin
                    cmd_ch.valid <= 1'b0;
                end
            end

            if (recv_stall > 0) begin
                rsp_ch.ready <= 1'b0;
                recv_stall   <= recv_stall - 1;
            end
            else if (idling_on && $urandom_range(0, 15) == 0) begin
                rsp_ch.ready <= 1'b0;
                recv_stall   <= $urandom_range(0, 9);
            end
            else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // Results are checked before the same edge's command is predicted; a result never
    // leaves in the cycle its command is accepted.
    always @(posedge clk) begin : watch_channels
        outcome_t want;
        if (rst_n) begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (announcer_outcomes.size() == 0) begin
                    $error("result transaction with no command waiting for it");
                    mismatches++;
                end
                else begin
                    want = announcer_outcomes.pop_front();
                    if (rsp_ch.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
                        mismatches++;
                    end
                    if (rsp_ch.played_call !== want.played) begin
                        $error("played_call: expected 0x%0h, got 0x%0h",
                               want.played, rsp_ch.played_call);
                        mismatches++;
                    end
                    if (rsp_ch.played_is_voice !== want.voice) begin
                        $error("played_is_voice: expected %0b, got %0b",
                               want.voice, rsp_ch.played_is_voice);
                        mismatches++;
                    end
                    if (rsp_ch.now_silent !== want.silent) begin
                        $error("now_silent: expected %0b, got %0b",
                               want.silent, rsp_ch.now_silent);
                        mismatches++;
                    end
                    case (want.status)
                        STATUS_RANGE:      range_refusals++;
                        STATUS_NOT_SILENT: silent_refusals++;
                        default:           ;
                    endcase
                end
            end
            if (cmd_ch.valid && cmd_ch.ready) begin
                want = announcer_step(cmd_ch.kind, cmd_ch.call_number);
                announcer_outcomes.push_back(want);
                cmds_accepted++;
                if (cmd_ch.kind == KIND_TICK && want.status == STATUS_DONE) begin
                    calls_played++;
                    if (want.voice)
                        voice_played++;
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("[paced_announcement_queue] ERROR");
            $finish;
        end
    end

    initial begin
        int gap_plan [8];
        int thr_plan [8];
        int p;
        gap_plan = '{0, 1, 0, 3, 6, 2, 0, 65535};
        thr_plan = '{0, 32767, 224, -1, -1, 1, 32767, -1};

        rst_n              = 1'b0;
        cmd_ch.valid       = 1'b0;
        cmd_ch.kind        = KIND_TICK;
        cmd_ch.call_number = '0;
        rsp_ch.ready       = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        wr_ptr             = 0;
        rd_ptr             = 0;
        holdoff            = '0;
        gap_cfg            = '0;
        voice_cfg          = VOICE_THRESHOLD_RESET;
        idling_on          = 1'b1;
        cycle_count        = 0;
        items_queued       = 0;
        cmds_accepted      = 0;
        mismatches         = 0;
        calls_played       = 0;
        voice_played       = 0;
        range_refusals     = 0;
        silent_refusals    = 0;
        settings_count     = 0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: one tick of hold-off after each play.
        apply_setting(1, 224);
        @(negedge clk);
        add_cmd(KIND_TICK, 16'hFFFF);            // empty queue, idle timer
        add_cmd(KIND_UNUSED, 16'hFFFF);          // unused kind
        add_cmd(KIND_ADD, 16'h8000);             // lowest out of range call
        add_cmd(KIND_ADD_IF_SILENT, MAX_CALL);   // silent, so accepted
        add_cmd(KIND_ADD_IF_SILENT, 16'h0000);   // queue not empty
        add_cmd(KIND_ADD_IF_SILENT, 16'hFFFF);   // not silent wins over out of range
        add_cmd(KIND_ADD, 16'h0000);
        add_cmd(KIND_ADD, 16'd224);
        add_cmd(KIND_TICK, 16'h0000);            // plays the largest call
        add_cmd(KIND_TICK, 16'h0000);            // timer running
        add_cmd(KIND_TICK, 16'h0000);            // plays zero
        add_cmd(KIND_TICK, 16'h0000);
        add_cmd(KIND_TICK, 16'h0000);            // plays the threshold itself
        add_cmd(KIND_TICK, 16'h0000);
        add_cmd(KIND_TICK, 16'h0000);            // nothing left
        // Eight adds bring the write pointer round onto the read pointer.
        for (p = 1; p <= SLOTS; p++)
            add_cmd(KIND_ADD, CALL_IN_W'(p));
        add_cmd(KIND_TICK, 16'h0000);
        wait_drained();

        for (p = 0; p < 8; p++) begin
            idling_on = (p != 7) && (p % 3 != 2);
            apply_setting(gap_plan[p],
                          (thr_plan[p] < 0) ? $urandom_range(0, 32767) : thr_plan[p]);
            fill_random(120);
            // The sender holds off here until every result is back.
            wait_drained();
            fill_random((p == 7) ? 30 : 120);
            wait_drained();
        end

        repeat (4) @(posedge clk);
        $display("Ran %0d commands over %0d register settings: %0d calls played (%0d voice),",
                 cmds_accepted, settings_count, calls_played, voice_played);
        $display("  %0d out-of-range and %0d not-silent refusals, overfill and idling included.",
                 range_refusals, silent_refusals);
        if (mismatches == 0)
            $display("[paced_announcement_queue] OK");
        else
            $display("[paced_announcement_queue] ERROR");
        $finish;
    end

endmodule
